// ===== src/vhs_pkg.sv =====
// ----------------------------------------------------------------------------
// vhs_pkg
// Shared types and constants for the decision hangover smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package vhs_pkg;

    // field and register widths
    localparam int FRAME_W      = 32;
    localparam int TRAP_W       = 6;
    localparam int CFG_IDX_W    = 1;

    // default depth of the pending frame store
    localparam int MAX_TRAP_DEF = 32;

    // reset values of the trap registers
    localparam logic [TRAP_W-1:0] SPEECH_TRAP_RST = 6'd5;
    localparam logic [TRAP_W-1:0] SIL_TRAP_RST    = 6'd20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_TRAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIL_TRAP    = 1'b1;

    // input commands
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_END   = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_TAIL
    } vhs_state_t;

endpackage

`default_nettype wire

// ===== src/vhs_in_if.sv =====
// ----------------------------------------------------------------------------
// vhs_in_if
// Decision channel: one raw frame decision or an end-of-stream command.
// ----------------------------------------------------------------------------
`default_nettype none

interface vhs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [vhs_pkg::FRAME_W-1:0]  frame_index;
    logic                         raw_is_silence;

    modport source (output valid, output command, output frame_index,
                    output raw_is_silence, input ready);
    modport sink   (input valid, input command, input frame_index,
                    input raw_is_silence, output ready);
endinterface

`default_nettype wire

// ===== src/vhs_out_if.sv =====
// ----------------------------------------------------------------------------
// vhs_out_if
// Label channel: one smoothed label per frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface vhs_out_if;
    logic                         valid;
    logic                         ready;
    logic [vhs_pkg::FRAME_W-1:0]  out_frame_index;
    logic                         is_speech;
    logic                         last_of_run;

    modport source (output valid, output out_frame_index, output is_speech,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_frame_index, input is_speech,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/vhs_pend_mem.sv =====
// ----------------------------------------------------------------------------
// vhs_pend_mem
// Pending frame index store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vhs_pend_mem #(
    parameter int DEPTH  = vhs_pkg::MAX_TRAP_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DATA_W = vhs_pkg::FRAME_W
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/vad_decision_hangover_smoother.sv =====
// ----------------------------------------------------------------------------
// vad_decision_hangover_smoother
// Hangover smoothing of raw per-frame silence/speech decisions.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake            payload
//  decision   in   valid/ready          command, frame_index, raw_is_silence
//  label      out  valid/ready          out_frame_index, is_speech, last_of_run
//  cfg        in   cfg_we (no stall)    cfg_index, cfg_wdata
//
//  An item that releases nothing leaves the sequencer in ST_IDLE. One that
//  releases pending frames runs ST_READ and ST_EMIT, then ST_TAIL when its
//  own frame follows; a frame that agrees with an empty store runs ST_TAIL
//  only. The single read port of the pending store sets the pace of one label
//  per cycle while the label register is free. Reset clears mode, pending
//  count and the sequencer; the store itself is not cleared. A stalled label
//  register holds the drain in place, while a new decision is still taken as
//  soon as the previous one has handed its last label to the label register.
// ----------------------------------------------------------------------------
`default_nettype none

module vad_decision_hangover_smoother #(
    parameter int MAX_TRAP = vhs_pkg::MAX_TRAP_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    vhs_in_if.sink                             decision,
    vhs_out_if.source                          label,
    input  wire logic                          cfg_we,
    input  wire logic [vhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vhs_pkg::TRAP_W-1:0]    cfg_wdata
);

    localparam int AW    = (MAX_TRAP > 1) ? $clog2(MAX_TRAP) : 1;
    localparam int CW    = $clog2(MAX_TRAP + 1);
    localparam int CMP_W = (CW > vhs_pkg::TRAP_W) ? CW : vhs_pkg::TRAP_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TRAP);

    vhs_pkg::vhs_state_t state_reg, state_next;

    logic [vhs_pkg::TRAP_W-1:0]  speech_trap_reg;
    logic [vhs_pkg::TRAP_W-1:0]  sil_trap_reg;
    logic                        mode_reg;
    logic [CW-1:0]               count_reg;
    logic [AW-1:0]               rd_ptr_reg;
    logic [AW-1:0]               last_ptr_reg;
    logic                        tail_reg;
    logic                        label_reg;
    logic [vhs_pkg::FRAME_W-1:0] frame_reg;

    logic                        out_valid_reg;
    logic [vhs_pkg::FRAME_W-1:0] out_index_reg;
    logic                        out_speech_reg;
    logic                        out_last_reg;

    logic                        acc;
    logic                        is_end;
    logic                        agrees;
    logic [CW-1:0]               push_count;
    logic [vhs_pkg::TRAP_W-1:0]  trap_sel;
    logic                        hit;
    logic [CW-1:0]               drain_n;
    logic                        out_free;

    logic                        wr_en;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [vhs_pkg::FRAME_W-1:0] rd_data;
    logic                        load_out;
    logic [vhs_pkg::FRAME_W-1:0] load_index;
    logic                        load_speech;
    logic                        load_last;

    // pending frame store
    vhs_pend_mem #(
        .DEPTH  (MAX_TRAP),
        .ADDR_W (AW),
        .DATA_W (vhs_pkg::FRAME_W)
    ) u_pend_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (decision.frame_index),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // decision decode
    assign decision.ready = (state_reg == vhs_pkg::ST_IDLE);
    assign acc        = decision.valid && decision.ready;
    assign is_end     = (decision.command == vhs_pkg::CMD_END);
    assign agrees     = mode_reg ? !decision.raw_is_silence : decision.raw_is_silence;
    assign push_count = (count_reg == CNT_MAX) ? count_reg : count_reg + CW'(1);
    assign trap_sel   = mode_reg ? sil_trap_reg : speech_trap_reg;
    assign hit        = (trap_sel == '0)
                        || (CMP_W'(push_count) >= CMP_W'(trap_sel))
                        || (push_count == CNT_MAX);
    assign drain_n    = (is_end || agrees) ? count_reg : push_count;
    assign wr_en      = acc && !is_end && !agrees && (count_reg != CNT_MAX);
    assign out_free   = !out_valid_reg || label.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vhs_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    if (is_end)
                    begin
                        state_next = (count_reg != '0) ? vhs_pkg::ST_READ : vhs_pkg::ST_IDLE;
                    end
                    else if (agrees)
                    begin
                        state_next = (count_reg != '0) ? vhs_pkg::ST_READ : vhs_pkg::ST_TAIL;
                    end
                    else
                    begin
                        state_next = hit ? vhs_pkg::ST_READ : vhs_pkg::ST_IDLE;
                    end
                end
            end
            vhs_pkg::ST_READ:
            begin
                state_next = vhs_pkg::ST_EMIT;
            end
            vhs_pkg::ST_EMIT:
            begin
                if (out_free && (rd_ptr_reg == last_ptr_reg))
                begin
                    state_next = tail_reg ? vhs_pkg::ST_TAIL : vhs_pkg::ST_IDLE;
                end
            end
            vhs_pkg::ST_TAIL:
            begin
                if (out_free)
                begin
                    state_next = vhs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vhs_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: store reads and label loads
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = rd_ptr_reg;
        load_out    = 1'b0;
        load_index  = rd_data;
        load_speech = label_reg;
        load_last   = 1'b0;
        unique case (state_reg)
            vhs_pkg::ST_IDLE:
            begin
                rd_en = 1'b0;
            end
            vhs_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            vhs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    load_last = (rd_ptr_reg == last_ptr_reg) && !tail_reg;
                    if (rd_ptr_reg != last_ptr_reg)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = rd_ptr_reg + AW'(1);
                    end
                end
            end
            vhs_pkg::ST_TAIL:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_index = frame_reg;
                    load_last  = 1'b1;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vhs_pkg::ST_IDLE;
            mode_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc)
            begin
                if (is_end || agrees)
                begin
                    count_reg <= '0;
                end
                else if (hit)
                begin
                    count_reg <= '0;
                    mode_reg  <= !mode_reg;
                end
                else
                begin
                    count_reg <= push_count;
                end
            end
        end
    end

    // trap registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speech_trap_reg <= vhs_pkg::SPEECH_TRAP_RST;
            sil_trap_reg    <= vhs_pkg::SIL_TRAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vhs_pkg::CFG_SPEECH_TRAP: speech_trap_reg <= cfg_wdata;
                vhs_pkg::CFG_SIL_TRAP:    sil_trap_reg    <= cfg_wdata;
                default:                  speech_trap_reg <= speech_trap_reg;
            endcase
        end
    end

    // drain bookkeeping
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_ptr_reg   <= '0;
            last_ptr_reg <= AW'(drain_n - CW'(1));
            tail_reg     <= !is_end && agrees;
            label_reg    <= (is_end || agrees) ? mode_reg : !mode_reg;
            frame_reg    <= decision.frame_index;
        end
        else if (rd_en && (state_reg == vhs_pkg::ST_EMIT))
        begin
            rd_ptr_reg <= rd_addr;
        end
    end

    // label register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (label.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_index_reg  <= load_index;
            out_speech_reg <= load_speech;
            out_last_reg   <= load_last;
        end
    end

    assign label.valid           = out_valid_reg;
    assign label.out_frame_index = out_index_reg;
    assign label.is_speech       = out_speech_reg;
    assign label.last_of_run     = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decision hangover smoother. A directed table
// covers reset behavior, trap extremes, flushes and a trap change while frames
// wait. Random runs of decisions then follow, shaped around the active trap
// lengths, under several trap settings. Labels are checked against the table
// or an in-bench smoothing model. Both channels see random idle cycles.
// ----------------------------------------------------------------------------

module tb;

    import vhs_pkg::*;

    localparam int DEPTH        = MAX_TRAP_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 39;

    localparam logic RAW_SIL    = 1'b1;
    localparam logic RAW_SPEECH = 1'b0;

    typedef struct packed {
        logic [FRAME_W-1:0] idx;
        logic               speech;
        logic               last;
    } label_t;

    typedef enum logic [1:0] {
        ROW_FRAME,
        ROW_END,
        ROW_CFG
    } row_op_t;

    typedef struct packed {
        row_op_t              op;
        logic                 sil;
        logic [FRAME_W-1:0]   idx;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [TRAP_W-1:0]    val;
        logic                 typed;
        logic                 one_res;
        logic                 t_speech;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TRAP_W-1:0]    cfg_wdata;

    vhs_in_if  dec_if ();
    vhs_out_if lab_if ();

    vad_decision_hangover_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .decision  (dec_if.sink),
        .label     (lab_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // smoother model state
    bit                 mode_speech;
    int                 pend_cnt;
    logic [FRAME_W-1:0] pend_idx [DEPTH];
    logic [TRAP_W-1:0]  speech_trap_q;
    logic [TRAP_W-1:0]  sil_trap_q;

    label_t release_q [$];
    label_t label_q [$];

    int          errors = 0;
    int          cycle_cnt = 0;
    bit          calm;
    int          stall_left = 0;
    logic [31:0] frame_ctr;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // trap as the smoother applies it
    function automatic int effective_hold(input logic [TRAP_W-1:0] t);
        if (t == 0)
            return 1;
        if (t > DEPTH)
            return DEPTH;
        return int'(t);
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [FRAME_W-1:0] next_index();
        if ($urandom_range(0, 7) == 0)
            return $urandom();
        frame_ctr = frame_ctr + 32'd1;
        return frame_ctr;
    endfunction

    // release every waiting frame under one label
    task automatic flush_pending(input bit speech);
        for (int i = 0; i < pend_cnt; i++)
            release_q.push_back('{pend_idx[i], speech, 1'b0});
        pend_cnt = 0;
    endtask

    // labels caused by one decision or end command
    task automatic smooth_decision(input logic cmd, input logic [FRAME_W-1:0] idx,
                                   input logic sil);
        bit     agrees;
        int     trap;
        label_t lbl;
        release_q.delete();
        if (cmd == CMD_END)
        begin
            flush_pending(mode_speech);
        end
        else
        begin
            agrees = mode_speech ? !sil : sil;
            if (agrees)
            begin
                flush_pending(mode_speech);
                release_q.push_back('{idx, mode_speech, 1'b0});
            end
            else
            begin
                trap = effective_hold(mode_speech ? sil_trap_q : speech_trap_q);
                if (pend_cnt < DEPTH)
                begin
                    pend_idx[pend_cnt] = idx;
                    pend_cnt++;
                end
                if (pend_cnt >= trap)
                begin
                    mode_speech = !mode_speech;
                    flush_pending(mode_speech);
                end
            end
        end
        if (release_q.size() > 0)
        begin
            lbl = release_q.pop_back();
            lbl.last = 1'b1;
            release_q.push_back(lbl);
        end
    endtask

    // one decision transfer, called and returning at a falling edge
    task automatic send_decision(input logic cmd, input logic [FRAME_W-1:0] idx,
                                 input logic sil, input bit typed,
                                 input bit one_res, input bit t_speech);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            dec_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        dec_if.valid          <= 1'b1;
        dec_if.command        <= cmd;
        dec_if.frame_index    <= idx;
        dec_if.raw_is_silence <= sil;
        do
            @(posedge clk);
        while (!dec_if.ready);
        smooth_decision(cmd, idx, sil);
        if (typed)
        begin
            if (one_res)
                label_q.push_back('{idx, t_speech, 1'b1});
        end
        else
        begin
            foreach (release_q[i])
                label_q.push_back(release_q[i]);
        end
        @(negedge clk);
    endtask

    // wait until every label is out and the sequencer has settled
    task automatic wait_idle();
        dec_if.valid <= 1'b0;
        while (label_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_trap(input logic [CFG_IDX_W-1:0] reg_sel,
                              input logic [TRAP_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= reg_sel;
        cfg_wdata <= val;
        if (reg_sel == CFG_SPEECH_TRAP)
            speech_trap_q = val;
        else
            sil_trap_q = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // label sink stalls
    always @(negedge clk)
    begin : label_stall
        int g;
        if (!rst_n)
        begin
            lab_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            lab_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            g = pick_gap();
            lab_if.ready <= (g == 0);
            stall_left   <= (g > 0) ? g - 1 : 0;
        end
    end

    // label check on each transfer
    always @(posedge clk)
    begin : label_check
        label_t want;
        if (rst_n && lab_if.valid && lab_if.ready)
        begin
            if (label_q.size() == 0)
            begin
                $display("%0t: unexpected label idx %h speech %b last %b", $time,
                         lab_if.out_frame_index, lab_if.is_speech, lab_if.last_of_run);
                errors++;
            end
            else
            begin
                want = label_q.pop_front();
                if (lab_if.out_frame_index !== want.idx)
                begin
                    $display("%0t: frame index expected %h actual %h", $time,
                             want.idx, lab_if.out_frame_index);
                    errors++;
                end
                if (lab_if.is_speech !== want.speech)
                begin
                    $display("%0t: is_speech of %h expected %b actual %b", $time,
                             want.idx, want.speech, lab_if.is_speech);
                    errors++;
                end
                if (lab_if.last_of_run !== want.last)
                begin
                    $display("%0t: last_of_run of %h expected %b actual %b", $time,
                             want.idx, want.last, lab_if.last_of_run);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t          dir_tab [24];
        logic [TRAP_W-1:0] ph_speech [5];
        logic [TRAP_W-1:0] ph_sil [5];
        int                sent;
        int                r;
        int                run_len;
        int                pick;
        int                trap;
        logic              odd_val;

        calm           = 1'b0;
        frame_ctr      = $urandom();
        mode_speech    = 1'b0;
        pend_cnt       = 0;
        speech_trap_q  = SPEECH_TRAP_RST;
        sil_trap_q     = SIL_TRAP_RST;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_SPEECH_TRAP;
        cfg_wdata             = '0;
        dec_if.valid          = 1'b0;
        dec_if.command        = CMD_FRAME;
        dec_if.frame_index    = '0;
        dec_if.raw_is_silence = RAW_SIL;

        ph_speech = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd2};
        ph_sil    = '{6'd1, 6'd63, 6'd0, 6'd32, 6'd3};

        dir_tab = '{
            // silence in silence mode after reset, index extremes
            '{ROW_FRAME, RAW_SIL,    32'h0000_0000, CFG_SPEECH_TRAP, 6'd0, 1'b1, 1'b1, 1'b0},
            '{ROW_FRAME, RAW_SIL,    32'hFFFF_FFFF, CFG_SPEECH_TRAP, 6'd0, 1'b1, 1'b1, 1'b0},
            // end with nothing waiting
            '{ROW_END,   RAW_SIL,    32'h0000_0000, CFG_SPEECH_TRAP, 6'd0, 1'b1, 1'b0, 1'b0},
            // broken speech run released as silence
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0010, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0011, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SIL,    32'h0000_0012, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            // end with a frame waiting
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0020, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_END,   RAW_SIL,    32'h0000_0000, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            // full speech run switches mode
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0030, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0031, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0032, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0033, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0034, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SPEECH, 32'hAAAA_5555, CFG_SPEECH_TRAP, 6'd0, 1'b1, 1'b1, 1'b1},
            // end in speech mode keeps the mode
            '{ROW_FRAME, RAW_SIL,    32'h5555_AAAA, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_END,   RAW_SIL,    32'h5555_AAAA, CFG_SPEECH_TRAP, 6'd0, 1'b1, 1'b1, 1'b1},
            // zero trap behaves as one
            '{ROW_CFG,   RAW_SIL,    32'h0000_0000, CFG_SIL_TRAP,    6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SIL,    32'h0000_0040, CFG_SPEECH_TRAP, 6'd0, 1'b1, 1'b1, 1'b0},
            // trap lowered below the waiting count
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0041, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0042, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0043, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            '{ROW_CFG,   RAW_SIL,    32'h0000_0000, CFG_SPEECH_TRAP, 6'd2, 1'b0, 1'b0, 1'b0},
            '{ROW_FRAME, RAW_SPEECH, 32'h0000_0044, CFG_SPEECH_TRAP, 6'd0, 1'b0, 1'b0, 1'b0},
            // trap above the store depth
            '{ROW_CFG,   RAW_SIL,    32'h0000_0000, CFG_SIL_TRAP,    6'd63, 1'b0, 1'b0, 1'b0}
        };

        // reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].op == ROW_CFG)
                write_trap(dir_tab[i].reg_sel, dir_tab[i].val);
            else
                send_decision((dir_tab[i].op == ROW_END) ? CMD_END : CMD_FRAME,
                              dir_tab[i].idx, dir_tab[i].sil, dir_tab[i].typed,
                              dir_tab[i].one_res, dir_tab[i].t_speech);
        end

        // random phases
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 5)
            begin
                write_trap(CFG_SPEECH_TRAP, ph_speech[p]);
                write_trap(CFG_SIL_TRAP, ph_sil[p]);
            end
            else
            begin
                write_trap(CFG_SPEECH_TRAP, TRAP_W'($urandom_range(1, 12)));
                write_trap(CFG_SIL_TRAP, TRAP_W'($urandom_range(1, 24)));
            end
            calm = (p % 3 == 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                begin
                    send_decision(CMD_END, $urandom(), 1'($urandom_range(0, 1)),
                                  1'b0, 1'b0, 1'b0);
                    sent++;
                end
                else if (r < 16)
                begin
                    send_decision(CMD_FRAME, next_index(), 1'($urandom_range(0, 1)),
                                  1'b0, 1'b0, 1'b0);
                    sent++;
                end
                else
                begin
                    // run against the current mode, cut at the trap or short of it
                    odd_val = mode_speech ? RAW_SIL : RAW_SPEECH;
                    trap = effective_hold(mode_speech ? sil_trap_q : speech_trap_q);
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        run_len = trap;
                    else if (pick == 1)
                        run_len = trap - 1;
                    else
                        run_len = $urandom_range(1, trap);
                    for (int k = 0; k < run_len; k++)
                        send_decision(CMD_FRAME, next_index(), odd_val,
                                      1'b0, 1'b0, 1'b0);
                    sent += run_len;
                    if (pick == 1)
                    begin
                        send_decision(CMD_FRAME, next_index(), !odd_val,
                                      1'b0, 1'b0, 1'b0);
                        sent++;
                    end
                end
            end
        end

        // drain
        dec_if.valid <= 1'b0;
        calm = 1'b0;
        while (label_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== vad_decision_hangover_smoother.f =====
src/vhs_pkg.sv
src/vhs_in_if.sv
src/vhs_out_if.sv
src/vhs_pend_mem.sv
src/vad_decision_hangover_smoother.sv
tb/tb.sv
